// ----- hdl/stdu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Solid tile detector package
// Operation codes and the command bundle of the shared multiply/divide unit.
// ---------------------------------------------------------------------------
package stdu_pkg;

    typedef enum logic [0:0] {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_cmd;

endpackage

// ----- hdl/stdu_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Solid tile detector channels
// Valid/ready channels for tile pixels and for tile results.
// ---------------------------------------------------------------------------
interface stdu_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_in_tile;

    modport source (output valid, red, green, blue, last_in_tile, input ready);
    modport sink (input valid, red, green, blue, last_in_tile, output ready);
endinterface

interface stdu_res_if;
    logic       valid;
    logic       ready;
    logic       is_solid;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;

    modport source (output valid, is_solid, avg_red, avg_green, avg_blue, input ready);
    modport sink (input valid, is_solid, avg_red, avg_green, avg_blue, output ready);
endinterface

// ----- hdl/stdu_accum.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tile accumulator
// Sums the channels, the gray value and its square for up to the tile limit.
// ---------------------------------------------------------------------------
module stdu_accum #(
    parameter int MAX_TILE_PIXELS = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_clear,
    input  logic [7:0]                                    i_red,
    input  logic [7:0]                                    i_green,
    input  logic [7:0]                                    i_blue,
    output logic [$clog2(255 * MAX_TILE_PIXELS + 1)-1:0]    o_sum_red,
    output logic [$clog2(255 * MAX_TILE_PIXELS + 1)-1:0]    o_sum_green,
    output logic [$clog2(255 * MAX_TILE_PIXELS + 1)-1:0]    o_sum_blue,
    output logic [$clog2(765 * MAX_TILE_PIXELS + 1)-1:0]    o_sum_gray,
    output logic [$clog2(585225 * MAX_TILE_PIXELS + 1)-1:0] o_sum_gray_sq,
    output logic [$clog2(MAX_TILE_PIXELS + 1)-1:0]          o_count
);

    localparam int CW  = $clog2(MAX_TILE_PIXELS + 1);
    localparam int SRW = $clog2(255 * MAX_TILE_PIXELS + 1);
    localparam int SGW = $clog2(765 * MAX_TILE_PIXELS + 1);
    localparam int SQW = $clog2(585225 * MAX_TILE_PIXELS + 1);

    logic [SRW-1:0] r_sum_red, r_sum_green, r_sum_blue;
    logic [SGW-1:0] r_sum_gray;
    logic [SQW-1:0] r_sum_gray_sq;
    logic [CW-1:0]  r_count;
    logic [9:0]     w_gray;
    logic [19:0]    w_gray_sq;
    logic           w_room;

    assign w_gray    = 10'(i_red) + 10'(i_green) + 10'(i_blue);
    assign w_gray_sq = 20'(w_gray) * 20'(w_gray);
    assign w_room    = r_count < CW'(MAX_TILE_PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum_red     <= '0;
            r_sum_green   <= '0;
            r_sum_blue    <= '0;
            r_sum_gray    <= '0;
            r_sum_gray_sq <= '0;
            r_count       <= '0;
        end else if (i_en && w_room) begin
            r_sum_red     <= r_sum_red + SRW'(i_red);
            r_sum_green   <= r_sum_green + SRW'(i_green);
            r_sum_blue    <= r_sum_blue + SRW'(i_blue);
            r_sum_gray    <= r_sum_gray + SGW'(w_gray);
            r_sum_gray_sq <= r_sum_gray_sq + SQW'(w_gray_sq);
            r_count       <= r_count + CW'(1);
        end
    end

    assign o_sum_red     = r_sum_red;
    assign o_sum_green   = r_sum_green;
    assign o_sum_blue    = r_sum_blue;
    assign o_sum_gray    = r_sum_gray;
    assign o_sum_gray_sq = r_sum_gray_sq;
    assign o_count       = r_count;

endmodule

// ----- hdl/stdu_mdu.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiply/divide unit
// Shift-add multiplier and restoring divider around one adder, one bit a cycle.
// ---------------------------------------------------------------------------
module stdu_mdu #(
    parameter int W = 37
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stdu_pkg::t_mdu_cmd i_cmd,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic              o_done,
    output logic [W-1:0]      o_result
);

    localparam int NW = $clog2(W + 1);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_div;
    logic          r_done;
    logic [W:0]    w_shifted;
    logic [W:0]    w_x;
    logic [W:0]    w_y;
    logic [W:0]    w_sum;

    // One adder serves both operations: add for multiply, subtract for divide.
    always_comb begin
        w_shifted = {r_acc, r_b[W-1]};
        w_x       = r_div ? w_shifted : {1'b0, r_acc};
        w_y       = {1'b0, r_a};
        w_sum     = w_x + (r_div ? ~w_y : w_y) + (W+1)'(r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_div  <= (i_cmd.op == stdu_pkg::MDU_DIV);
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_sum[W]) begin
                    r_acc <= w_sum[W-1:0];
                end else begin
                    r_acc <= w_shifted[W-1:0];
                end
                r_b <= {r_b[W-2:0], ~w_sum[W]};
            end else begin
                if (r_b[0]) begin
                    r_acc <= w_sum[W-1:0];
                end
                r_a <= {r_a[W-2:0], 1'b0};
                r_b <= {1'b0, r_b[W-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? r_b : r_acc;

endmodule

// ----- hdl/solid_tile_detector_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Solid tile detector
// Accumulates tile statistics, tests luminance spread and reports averages for solid tiles.
// ---------------------------------------------------------------------------
// Pixels are taken one per cycle while no tile end is in progress. After the
// marked pixel, the shared multiply/divide unit runs three products and, for a
// solid tile, three quotients on W-bit operands (W = 37 at the default tile limit);
// no pixel is accepted until the tile has been loaded into the result register,
// which may wait for the result register to be free. Synchronous active-low
// reset clears the accumulators, the sequencer and the result valid flag.
module solid_tile_detector_unit #(
    parameter int MAX_TILE_PIXELS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stdu_pix_if.sink    i_pix,
    stdu_res_if.source  o_res
);

    localparam int CW  = $clog2(MAX_TILE_PIXELS + 1);
    localparam int SRW = $clog2(255 * MAX_TILE_PIXELS + 1);
    localparam int SGW = $clog2(765 * MAX_TILE_PIXELS + 1);
    localparam int SQW = $clog2(585225 * MAX_TILE_PIXELS + 1);
    localparam int WA  = CW + SQW;
    localparam int WB  = 2 * SGW;
    localparam int WC  = 2 * CW + 4;
    localparam int WAB = (WA > WB) ? WA : WB;
    localparam int W   = (WAB > WC) ? WAB : WC;

    typedef enum logic [8:0] {
        S_ACC = 9'b000000001,
        S_LHS = 9'b000000010,
        S_SQ  = 9'b000000100,
        S_THR = 9'b000001000,
        S_CMP = 9'b000010000,
        S_DR  = 9'b000100000,
        S_DG  = 9'b001000000,
        S_DB  = 9'b010000000,
        S_WB  = 9'b100000000
    } t_state;

    t_state             r_state;
    logic               r_issued;
    logic [W-1:0]       r_lhs;
    logic [W-1:0]       r_sq;
    logic [W-1:0]       r_thr;
    logic               r_solid;
    logic [7:0]         r_avg_red, r_avg_green, r_avg_blue;
    logic               r_out_valid;
    logic               r_out_solid;
    logic [7:0]         r_out_red, r_out_green, r_out_blue;

    logic               w_accept;
    logic               w_clear;
    logic               w_load;
    logic [SRW-1:0]     w_sum_red, w_sum_green, w_sum_blue;
    logic [SGW-1:0]     w_sum_gray;
    logic [SQW-1:0]     w_sum_gray_sq;
    logic [CW-1:0]      w_count;
    logic [W-1:0]       w_n;
    stdu_pkg::t_mdu_cmd w_cmd;
    logic [W-1:0]       w_a;
    logic [W-1:0]       w_b;
    logic               w_done;
    logic [W-1:0]       w_result;
    logic [W:0]         w_bound;

    assign i_pix.ready = (r_state == S_ACC);
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_load      = (r_state == S_WB) && (!r_out_valid || o_res.ready);
    assign w_clear     = w_load;
    assign w_n         = W'(w_count);

    stdu_accum #(
        .MAX_TILE_PIXELS(MAX_TILE_PIXELS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_accept),
        .i_clear      (w_clear),
        .i_red        (i_pix.red),
        .i_green      (i_pix.green),
        .i_blue       (i_pix.blue),
        .o_sum_red    (w_sum_red),
        .o_sum_green  (w_sum_green),
        .o_sum_blue   (w_sum_blue),
        .o_sum_gray   (w_sum_gray),
        .o_sum_gray_sq(w_sum_gray_sq),
        .o_count      (w_count)
    );

    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.op    = stdu_pkg::MDU_MUL;
        w_a         = w_n;
        w_b         = W'(w_sum_gray_sq);
        unique case (r_state)
            S_LHS: begin
                w_cmd.start = !r_issued;
            end
            S_SQ: begin
                w_cmd.start = !r_issued;
                w_a         = W'(w_sum_gray);
                w_b         = W'(w_sum_gray);
            end
            S_THR: begin
                w_cmd.start = !r_issued;
                w_b         = w_n + {w_n[W-4:0], 3'b000};
            end
            S_DR: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = stdu_pkg::MDU_DIV;
                w_b         = W'(w_sum_red);
            end
            S_DG: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = stdu_pkg::MDU_DIV;
                w_b         = W'(w_sum_green);
            end
            S_DB: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = stdu_pkg::MDU_DIV;
                w_b         = W'(w_sum_blue);
            end
            S_ACC, S_CMP, S_WB: begin
                w_cmd.start = 1'b0;
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    stdu_mdu #(
        .W(W)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_result(w_result)
    );

    // The tile is solid when n*sum(s^2) is below sum(s)^2 + 9*n^2.
    assign w_bound = {1'b0, r_sq} + {1'b0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_issued <= 1'b0;
        end else begin
            if (w_cmd.start) begin
                r_issued <= 1'b1;
            end
            if (w_done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_ACC: begin
                    if (w_accept && i_pix.last_in_tile) begin
                        r_state <= S_LHS;
                    end
                end
                S_LHS: begin
                    if (w_done) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_done) begin
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    if (w_done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= ({1'b0, r_lhs} < w_bound) ? S_DR : S_WB;
                end
                S_DR: begin
                    if (w_done) begin
                        r_state <= S_DG;
                    end
                end
                S_DG: begin
                    if (w_done) begin
                        r_state <= S_DB;
                    end
                end
                S_DB: begin
                    if (w_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_load) begin
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LHS && w_done) begin
            r_lhs <= w_result;
        end
        if (r_state == S_SQ && w_done) begin
            r_sq <= w_result;
        end
        if (r_state == S_THR && w_done) begin
            r_thr <= w_result;
        end
        if (r_state == S_CMP) begin
            r_solid     <= ({1'b0, r_lhs} < w_bound);
            r_avg_red   <= '0;
            r_avg_green <= '0;
            r_avg_blue  <= '0;
        end
        if (r_state == S_DR && w_done) begin
            r_avg_red <= w_result[7:0];
        end
        if (r_state == S_DG && w_done) begin
            r_avg_green <= w_result[7:0];
        end
        if (r_state == S_DB && w_done) begin
            r_avg_blue <= w_result[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_solid <= r_solid;
            r_out_red   <= r_avg_red;
            r_out_green <= r_avg_green;
            r_out_blue  <= r_avg_blue;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.is_solid  = r_out_solid;
    assign o_res.avg_red   = r_out_red;
    assign o_res.avg_green = r_out_green;
    assign o_res.avg_blue  = r_out_blue;

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(MAX_TILE_PIXELS))
        else $error("Pixel count exceeds the tile limit.");

    a_zero_when_not_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_solid) |->
        (o_res.avg_red == 8'd0 && o_res.avg_green == 8'd0 && o_res.avg_blue == 8'd0))
        else $error("A tile that is not solid carries nonzero averages.");

    a_done_in_op_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_LHS || r_state == S_SQ || r_state == S_THR ||
                    r_state == S_DR || r_state == S_DG || r_state == S_DB))
        else $error("Arithmetic unit finished outside an operation state.");

    a_no_pixels_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_pix.last_in_tile) |=> !i_pix.ready)
        else $error("Pixel channel ready right after the closing pixel.");

endmodule
